### hw/rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Types and constants shared by the minimum squared-error lag search.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int SUM_W         = 48;
	localparam int CNT_W         = 11;
	localparam int LAG_W         = 5;
	localparam int MAX_SAMPLES   = 1024;
	localparam int MAX_SHIFT_RST = 4;

	typedef logic signed [SAMPLE_W-1:0]  sample_t;
	typedef logic signed [SAMPLE_W:0]    diff_t;
	typedef logic signed [2*SAMPLE_W+1:0] prod_t;
	typedef logic [2*SAMPLE_W+1:0]        sq_t;
	typedef logic [SUM_W-1:0]             sum_t;
	typedef logic [SUM_W:0]               sum_ext_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [LAG_W-1:0]             lag_t;

	typedef struct packed {
		sample_t model_sample;
		sample_t reference_sample;
		logic    last_sample;
	} in_req_t;

	typedef struct packed {
		lag_t best_lag;
		sum_t min_error_sum;
		cnt_t sample_count;
		logic overflow_flag;
	} out_res_t;

	// per-cycle control broadcast along the cell chain
	typedef struct packed {
		logic take;
		logic last;
		logic flush;
	} cell_ctl_t;

	// series totals that travel beside the minimum search
	typedef struct packed {
		cnt_t count;
		logic ovf;
	} tag_t;

endpackage

`default_nettype wire

### hw/rtl/mss_cell.sv
// ----------------------------------------------------------------------------
// mss_cell
// One lag of the search: delay tap, squared difference and saturating sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  mss_pkg::cell_ctl_t  ctl,
	input  wire                 lag_en,
	input  mss_pkg::sample_t    ref_smp,
	input  mss_pkg::sample_t    dly_in,
	input  wire                 dly_vld_in,
	output mss_pkg::sample_t    dly_out,
	output logic                dly_vld_out,
	output mss_pkg::sum_t       snap,
	output logic                sat
);

	mss_pkg::diff_t    diff;
	mss_pkg::prod_t    prod;
	mss_pkg::sq_t      sq_s1;
	logic              act_s1;
	mss_pkg::sample_t  dly_q;
	logic              dly_vld_q;
	mss_pkg::sum_t     sum_q;
	mss_pkg::sum_ext_t sum_ext;
	mss_pkg::sum_t     sum_new;

	always_comb begin
		diff = mss_pkg::diff_t'(dly_in) - mss_pkg::diff_t'(ref_smp);
		prod = diff * diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1    <= 1'b0;
			dly_vld_q <= 1'b0;
		end else begin
			act_s1 <= ctl.take && lag_en && dly_vld_in;
			if (ctl.take) begin
				dly_vld_q <= ctl.last ? 1'b0 : dly_vld_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			sq_s1 <= mss_pkg::sq_t'(prod);
			dly_q <= dly_in;
		end
	end

	// saturating accumulate
	always_comb begin
		sum_ext = {1'b0, sum_q} + mss_pkg::sum_ext_t'(sq_s1);
		if (!act_s1) begin
			sum_new = sum_q;
		end else if (sum_ext[mss_pkg::SUM_W]) begin
			sum_new = '1;
		end else begin
			sum_new = sum_ext[mss_pkg::SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else begin
			sum_q <= ctl.flush ? '0 : sum_new;
		end
	end

	assign snap        = sum_new;
	assign sat         = act_s1 && sum_ext[mss_pkg::SUM_W];
	assign dly_out     = dly_q;
	assign dly_vld_out = dly_vld_q;

endmodule

`default_nettype wire

### hw/rtl/mss_min_tree.sv
// ----------------------------------------------------------------------------
// mss_min_tree
// Registered pairwise minimum over the lag sums, lower lag wins on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_min_tree #(
	parameter int N_LEAF = 17
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         in_vld,
	input  wire [N_LEAF-1:0][mss_pkg::SUM_W-1:0]        leaf_sum,
	input  wire [N_LEAF-1:0]                            leaf_en,
	input  mss_pkg::tag_t                               tag_in,
	output logic                                        out_vld,
	output mss_pkg::out_res_t                           res
);

	localparam int LVL = (N_LEAF > 1) ? $clog2(N_LEAF) : 1;
	localparam int P   = 1 << LVL;

	wire [mss_pkg::SUM_W-1:0] nsum [LVL+1][P];
	wire [LVL-1:0]            nlag [LVL+1][P];
	wire                      nen  [LVL+1][P];
	wire                      vld  [LVL+1];
	wire [mss_pkg::CNT_W-1:0] tcnt [LVL+1];
	wire                      tovf [LVL+1];

	assign vld[0]  = in_vld;
	assign tcnt[0] = tag_in.count;
	assign tovf[0] = tag_in.ovf;

	for (genvar i = 0; i < P; i++) begin : g_leaf
		assign nlag[0][i] = LVL'(i);
		if (i < N_LEAF) begin : g_real
			assign nsum[0][i] = leaf_sum[i];
			assign nen[0][i]  = leaf_en[i];
		end else begin : g_pad
			assign nsum[0][i] = '1;
			assign nen[0][i]  = 1'b0;
		end
	end

	for (genvar k = 0; k < LVL; k++) begin : g_lvl
		logic          vld_q;
		mss_pkg::cnt_t cnt_q;
		logic          ovf_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= 1'b0;
			end else begin
				vld_q <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (vld[k]) begin
				cnt_q <= tcnt[k];
				ovf_q <= tovf[k];
			end
		end

		assign vld[k+1]  = vld_q;
		assign tcnt[k+1] = cnt_q;
		assign tovf[k+1] = ovf_q;

		for (genvar i = 0; i < (P >> (k + 1)); i++) begin : g_node
			logic           pick_r;
			mss_pkg::sum_t  sum_q;
			logic [LVL-1:0] lag_q;
			logic           en_q;

			assign pick_r = nen[k][2*i+1] &&
				(!nen[k][2*i] || (nsum[k][2*i+1] < nsum[k][2*i]));

			always_ff @(posedge clk) begin
				if (vld[k]) begin
					sum_q <= pick_r ? nsum[k][2*i+1] : nsum[k][2*i];
					lag_q <= pick_r ? nlag[k][2*i+1] : nlag[k][2*i];
					en_q  <= nen[k][2*i] | nen[k][2*i+1];
				end
			end

			assign nsum[k+1][i] = sum_q;
			assign nlag[k+1][i] = lag_q;
			assign nen[k+1][i]  = en_q;
		end
	end

	assign out_vld           = vld[LVL];
	assign res.best_lag      = mss_pkg::lag_t'(nlag[LVL][0]);
	assign res.min_error_sum = nsum[LVL][0];
	assign res.sample_count  = tcnt[LVL];
	assign res.overflow_flag = tovf[LVL];

endmodule

`default_nettype wire

### hw/rtl/mss_res_fifo.sv
// ----------------------------------------------------------------------------
// mss_res_fifo
// Small result queue in front of the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_res_fifo #(
	parameter int DEPTH = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  mss_pkg::out_res_t  push_res,
	output logic               out_valid,
	input  wire                out_ready,
	output mss_pkg::out_res_t  out_res
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mss_pkg::out_res_t mem_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              pop;

	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];

endmodule

`default_nettype wire

### hw/rtl/min_sse_lag_search.sv
// ----------------------------------------------------------------------------
// min_sse_lag_search
// Finds the lag with the smallest sum of squared differences between a
// delayed model series and a reference series.
// ----------------------------------------------------------------------------
// One sample pair is taken every clock while in_ready is high. A row of
// MAX_SHIFT+1 cells holds the model delay line and one 48-bit saturating
// sum per lag; each cell squares its difference in the accept cycle and
// adds it in the following cycle. The pair marked last_sample closes the
// series: its sums are handed to a registered minimum tree of
// clog2(MAX_SHIFT+1) levels and the cells clear, so the next series may
// start in the very next cycle. A result reaches the output through the
// square stage, the tree levels (the first of which also takes the final
// add) and the result queue. The queue holds clog2(MAX_SHIFT+1)+3 results;
// in_ready drops only while that many results are pending behind a stalled
// output.
// ----------------------------------------------------------------------------
`default_nettype none

module min_sse_lag_search #(
	parameter int MAX_SHIFT = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  mss_pkg::lag_t       cfg_wdata,
	input  wire                 in_valid,
	output logic                in_ready,
	input  mss_pkg::in_req_t    in_req,
	output logic                out_valid,
	input  wire                 out_ready,
	output mss_pkg::out_res_t   out_res
);

	localparam int N_CELL    = MAX_SHIFT + 1;
	localparam int TREE_LVL  = $clog2(N_CELL);
	localparam int RES_DEPTH = TREE_LVL + 3;
	localparam int RW        = $clog2(RES_DEPTH + 1);

	mss_pkg::lag_t      max_shift_q;
	logic               take;
	mss_pkg::cell_ctl_t ctl;
	logic [N_CELL-1:0]  lag_en;

	mss_pkg::sample_t   dly     [N_CELL+1];
	logic               dly_vld [N_CELL+1];
	logic [N_CELL-1:0][mss_pkg::SUM_W-1:0] snap;
	logic [N_CELL-1:0]  cell_sat;

	mss_pkg::cnt_t      pair_cnt_q;
	mss_pkg::cnt_t      cnt_inc;
	logic               cnt_full;
	mss_pkg::cnt_t      cnt_s1;
	logic               cnt_sat_s1;
	logic               last_s1;
	logic               sat_q;
	logic               sat_now;
	mss_pkg::tag_t      tag_s1;

	logic               tree_vld;
	mss_pkg::out_res_t  tree_res;
	logic               pop;
	logic [RW-1:0]      res_cnt_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_shift_q <= mss_pkg::lag_t'(mss_pkg::MAX_SHIFT_RST);
		end else if (cfg_we) begin
			max_shift_q <= cfg_wdata;
		end
	end

	assign in_ready  = (res_cnt_q < RW'(RES_DEPTH));
	assign take      = in_valid && in_ready;
	assign ctl.take  = take;
	assign ctl.last  = in_req.last_sample;
	assign ctl.flush = last_s1;

	// cell row
	assign dly[0]     = in_req.model_sample;
	assign dly_vld[0] = 1'b1;

	for (genvar g = 0; g < N_CELL; g++) begin : g_cell
		assign lag_en[g] = (32'(max_shift_q) >= 32'(g));

		mss_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.lag_en      (lag_en[g]),
			.ref_smp     (in_req.reference_sample),
			.dly_in      (dly[g]),
			.dly_vld_in  (dly_vld[g]),
			.dly_out     (dly[g+1]),
			.dly_vld_out (dly_vld[g+1]),
			.snap        (snap[g]),
			.sat         (cell_sat[g])
		);
	end

	// pair count
	assign cnt_full = (pair_cnt_q >= mss_pkg::cnt_t'(mss_pkg::MAX_SAMPLES));
	assign cnt_inc  = cnt_full ? pair_cnt_q : pair_cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cnt_q <= '0;
			cnt_sat_s1 <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			cnt_sat_s1 <= take && cnt_full;
			last_s1    <= take && in_req.last_sample;
			if (take) begin
				pair_cnt_q <= in_req.last_sample ? '0 : cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cnt_s1 <= cnt_inc;
		end
	end

	// sticky saturation
	assign sat_now = sat_q || cnt_sat_s1 || (|cell_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else begin
			sat_q <= last_s1 ? 1'b0 : sat_now;
		end
	end

	assign tag_s1.count = cnt_s1;
	assign tag_s1.ovf   = sat_now;

	mss_min_tree #(
		.N_LEAF (N_CELL)
	) u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (last_s1),
		.leaf_sum (snap),
		.leaf_en  (lag_en),
		.tag_in   (tag_s1),
		.out_vld  (tree_vld),
		.res      (tree_res)
	);

	mss_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tree_vld),
		.push_res  (tree_res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// results reserved between a last pair and its delivery
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else begin
			if ((take && in_req.last_sample) && !pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (pop && !(take && in_req.last_sample)) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mss_checker.sv
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks for the lag search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_checker #(
	parameter int MAX_SHIFT = 16
) (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_ready,
	input mss_pkg::in_req_t   in_req,
	input wire                out_valid,
	input wire                out_ready,
	input mss_pkg::out_res_t  out_res
);

	// stalled request keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_req))
		else $error("input request dropped or changed while stalled");

	// stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_res))
		else $error("result dropped or changed while stalled");

	// winning lag is one of the built lags
	a_lag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_res.best_lag) <= MAX_SHIFT))
		else $error("best lag beyond the cell row");

	// a series has at least one pair and the count saturates
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.sample_count != '0) &&
			(out_res.sample_count <= mss_pkg::cnt_t'(mss_pkg::MAX_SAMPLES)))
		else $error("sample count out of range");

endmodule

bind min_sse_lag_search mss_checker #(.MAX_SHIFT(MAX_SHIFT)) u_mss_checker (.*);

`default_nettype wire
